### src/sorted_table_insert_search_unit_defines.svh
// assertion macros for the sorted table insert and search unit
`ifndef SORTED_TABLE_INSERT_SEARCH_UNIT_DEFINES_SVH
`define SORTED_TABLE_INSERT_SEARCH_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define STSU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define STSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/stsu_pkg.sv
// shared types and codes for the sorted table insert and search unit
package stsu_pkg;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FIRST = 7'b0000010,
    S_LAST  = 7'b0000100,
    S_MID   = 7'b0001000,
    S_SHIFT = 7'b0010000,
    S_PUT   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

endpackage

### src/stsu_ram.sv
// generic single-write, single-read ram with registered read data
module stsu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/sorted_table_insert_search_unit.sv
// sorted key table with binary-search insert and search over one ram
// one request at a time
// insert moves each entry at or above its slot up by one, up to TABLE_DEPTH - 1 entries, then writes the key
// the finished result waits in an output register, so the next request is taken meanwhile
// synchronous reset clears the entry count, key_signed, out_valid and the sequencer
// table contents stay undefined after reset; no clearing pass is run
module sorted_table_insert_search_unit #(
  parameter int TABLE_DEPTH = 256,
  parameter int KEY_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [31:0] key,
  input  logic        bracket,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  result_index,
  output logic        exact_hit,
  output logic        index_valid,
  output logic        table_full,
  output logic [8:0]  entries_now
);
  import stsu_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  state_t state, state_next;

  logic                key_signed;
  logic [CNT_W-1:0]    count, count_next;
  logic [KEY_BITS-1:0] key_r;
  logic                req_r, brk_r;
  logic [CNT_W-1:0]    n_r;
  logic [IDX_W-1:0]    lo, lo_next, hi, hi_next, pos, pos_next, sp, sp_next;

  logic [IDX_W-1:0]    res_idx, res_idx_next;
  logic                res_hit, res_hit_next, res_valid, res_valid_next;
  logic                res_full, res_full_next;
  logic [CNT_W-1:0]    res_cnt, res_cnt_next;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr, ram_raddr;
  logic [KEY_BITS-1:0] ram_wdata, rd_data;

  logic [KEY_BITS+31:0] key_ext;
  logic [KEY_BITS-1:0]  key_in, sflip;
  logic                 lt, eq, gt;
  logic [CNT_W-1:0]     n_m1;
  logic [IDX_W-1:0]     last, n_low, mid_cur, nlo, nhi, sp_m1, f_lo, f_hi, ins_pos;
  logic [IDX_W:0]       cur_sum, new_sum, new_diff, last_ext;
  logic                 loc_done, loc_hit, loc_below, loc_above, out_load;
  logic [IDX_W+7:0]     idx_wide;
  logic [CNT_W+8:0]     cnt_wide;

  stsu_ram #(
    .WIDTH(KEY_BITS),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rd_data)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  assign key_ext = {{KEY_BITS{1'b0}}, key};
  assign key_in  = key_ext[KEY_BITS-1:0];

  // signed order by flipping the sign bit on both sides
  assign sflip = KEY_BITS'(key_signed) << (KEY_BITS - 1);
  assign lt    = (rd_data ^ sflip) < (key_r ^ sflip);
  assign eq    = (rd_data == key_r);
  assign gt    = !lt && !eq;

  assign n_m1     = n_r - 1'b1;
  assign last     = n_m1[IDX_W-1:0];
  assign last_ext = {1'b0, last};
  assign n_low    = n_r[IDX_W-1:0];
  assign cur_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid_cur  = cur_sum[IDX_W:1];
  assign nlo      = gt ? lo : mid_cur;
  assign nhi      = gt ? mid_cur : hi;
  assign new_sum  = {1'b0, nlo} + {1'b0, nhi};
  assign new_diff = {1'b0, nhi} - {1'b0, nlo};
  assign sp_m1    = sp - 1'b1;
  assign ins_pos  = loc_below ? '0 : (loc_above ? n_low : f_hi);
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next     = state;
    count_next     = count;
    lo_next        = lo;
    hi_next        = hi;
    pos_next       = pos;
    sp_next        = sp;
    res_idx_next   = res_idx;
    res_hit_next   = res_hit;
    res_valid_next = res_valid;
    res_full_next  = res_full;
    res_cnt_next   = res_cnt;
    ram_we         = 1'b0;
    ram_waddr      = sp;
    ram_wdata      = rd_data;
    ram_raddr      = '0;
    loc_done       = 1'b0;
    loc_hit        = 1'b0;
    loc_below      = 1'b0;
    loc_above      = 1'b0;
    f_lo           = '0;
    f_hi           = '0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          res_idx_next   = '0;
          res_hit_next   = 1'b0;
          res_valid_next = 1'b0;
          res_full_next  = 1'b0;
          res_cnt_next   = count;
          if (count == '0) begin
            if (req_type == REQ_INSERT) begin
              ram_we         = 1'b1;
              ram_waddr      = '0;
              ram_wdata      = key_in;
              count_next     = CNT_W'(1);
              res_valid_next = 1'b1;
              res_cnt_next   = CNT_W'(1);
            end
            state_next = S_DONE;
          end else begin
            state_next = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        if (!lt) begin
          loc_done  = 1'b1;
          loc_hit   = eq;
          loc_below = !eq;
        end else begin
          ram_raddr  = last;
          state_next = S_LAST;
        end
      end
      S_LAST: begin
        if (!gt) begin
          loc_done  = 1'b1;
          loc_hit   = eq;
          loc_above = !eq;
          f_lo      = last;
          f_hi      = last;
        end else if (last_ext > (IDX_W+1)'(1)) begin
          lo_next    = '0;
          hi_next    = last;
          ram_raddr  = last >> 1;
          state_next = S_MID;
        end else begin
          loc_done = 1'b1;
          f_lo     = '0;
          f_hi     = last;
        end
      end
      S_MID: begin
        if (eq) begin
          loc_done = 1'b1;
          loc_hit  = 1'b1;
          f_lo     = mid_cur;
          f_hi     = mid_cur;
        end else if (new_diff > (IDX_W+1)'(1)) begin
          lo_next   = nlo;
          hi_next   = nhi;
          ram_raddr = new_sum[IDX_W:1];
        end else begin
          loc_done = 1'b1;
          f_lo     = nlo;
          f_hi     = nhi;
        end
      end
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = sp;
        ram_wdata = rd_data;
        sp_next   = sp_m1;
        if (sp_m1 > pos) begin
          ram_raddr = sp_m1 - 1'b1;
        end else begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        ram_we         = 1'b1;
        ram_waddr      = pos;
        ram_wdata      = key_r;
        count_next     = n_r + 1'b1;
        res_idx_next   = pos;
        res_valid_next = 1'b1;
        res_cnt_next   = n_r + 1'b1;
        state_next     = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (loc_done) begin
      res_cnt_next   = n_r;
      res_idx_next   = '0;
      res_hit_next   = 1'b0;
      res_valid_next = 1'b0;
      res_full_next  = 1'b0;
      state_next     = S_DONE;
      if (loc_hit) begin
        res_idx_next   = f_hi;
        res_hit_next   = 1'b1;
        res_valid_next = 1'b1;
      end else if (req_r == REQ_INSERT) begin
        if (n_r == CNT_W'(TABLE_DEPTH)) begin
          res_full_next = 1'b1;
        end else begin
          pos_next = ins_pos;
          if (ins_pos == n_low) begin
            state_next = S_PUT;
          end else begin
            ram_raddr  = last;
            sp_next    = n_low;
            state_next = S_SHIFT;
          end
        end
      end else if (brk_r && !loc_below) begin
        res_idx_next   = f_lo;
        res_valid_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      key_signed <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cfg_valid) begin
        key_signed <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign idx_wide = {8'b0, res_idx};
  assign cnt_wide = {9'b0, res_cnt};

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      key_r <= key_in;
      req_r <= req_type;
      brk_r <= bracket;
      n_r   <= count;
    end
    lo        <= lo_next;
    hi        <= hi_next;
    pos       <= pos_next;
    sp        <= sp_next;
    res_idx   <= res_idx_next;
    res_hit   <= res_hit_next;
    res_valid <= res_valid_next;
    res_full  <= res_full_next;
    res_cnt   <= res_cnt_next;
    if (out_load) begin
      result_index <= idx_wide[7:0];
      exact_hit    <= res_hit;
      index_valid  <= res_valid;
      table_full   <= res_full;
      entries_now  <= cnt_wide[8:0];
    end
  end

endmodule

### src/stsu_checker.sv
// port-level checks on result beats of the sorted table unit, with bind
`include "sorted_table_insert_search_unit_defines.svh"

module stsu_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] result_index,
  input logic       exact_hit,
  input logic       index_valid,
  input logic       table_full
);

  // a stalled result beat holds
  `STSU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_index) && $stable(exact_hit) && $stable(index_valid) && $stable(table_full), "result beat changed while stalled")

  `STSU_ASSERT_NOW(a_idx_zero, out_valid && !index_valid, result_index == 8'd0, "result_index not zero without index_valid")

  `STSU_ASSERT_NOW(a_full_clean, out_valid && table_full, !index_valid && !exact_hit, "refused insert carries an index")

  `STSU_ASSERT_NOW(a_hit_valid, out_valid && exact_hit, index_valid, "exact hit without valid index")

endmodule

bind sorted_table_insert_search_unit stsu_checker u_stsu_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .result_index(result_index),
  .exact_hit   (exact_hit),
  .index_valid (index_valid),
  .table_full  (table_full)
);

### tb/sv/tb_sorted_table_insert_search_unit.sv
// testbench for the sorted table insert and search unit, checked beat by beat
module tb_sorted_table_insert_search_unit;
  import stsu_pkg::*;

  localparam int TABLE_DEPTH = 256;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int END_WAIT = 300;
  localparam int LONG_HOLD = 400;
  localparam int N_DIRECTED = 22;

  typedef struct packed {
    logic [7:0] slot;
    logic       hit;
    logic       slot_valid;
    logic       full;
    logic [8:0] entries;
  } lookup_result_t;

  typedef struct packed {
    logic           req;
    logic [31:0]    k;
    logic           br;
    logic           typed;
    lookup_result_t want;
  } stim_row_t;

  typedef enum int {PLACE_MATCH, PLACE_BELOW, PLACE_ABOVE, PLACE_BETWEEN} place_t;

  localparam lookup_result_t NO_RESULT = '0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        req_type = 1'b0;
  logic [31:0] key = '0;
  logic        bracket = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  result_index;
  logic        exact_hit;
  logic        index_valid;
  logic        table_full;
  logic [8:0]  entries_now;

  logic [31:0]    table_model [TABLE_DEPTH];
  int             model_count = 0;
  bit             model_signed = 1'b0;
  lookup_result_t pending_results[$];
  int             err_count = 0;
  int             cycle_count = 0;
  int             send_idle_pct = 0;
  int             recv_idle_pct = 0;
  logic           long_hold_go = 1'b0;
  bit             hold_taken = 1'b0;
  int             hold_left = 0;

  // typed rows: empty table after reset and the first insert
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{REQ_SEARCH, 32'h0000_0000, 1'b0, 1'b1, '{8'd0, 1'b0, 1'b0, 1'b0, 9'd0}},
    '{REQ_SEARCH, 32'hFFFF_FFFF, 1'b1, 1'b1, '{8'd0, 1'b0, 1'b0, 1'b0, 9'd0}},
    '{REQ_INSERT, 32'h0000_1000, 1'b0, 1'b1, '{8'd0, 1'b0, 1'b1, 1'b0, 9'd1}},
    '{REQ_SEARCH, 32'h0000_0005, 1'b1, 1'b0, NO_RESULT},
    '{REQ_SEARCH, 32'h0000_0005, 1'b0, 1'b0, NO_RESULT},
    '{REQ_SEARCH, 32'h0000_2000, 1'b1, 1'b0, NO_RESULT},
    '{REQ_SEARCH, 32'h0000_2000, 1'b0, 1'b0, NO_RESULT},
    '{REQ_SEARCH, 32'h0000_1000, 1'b1, 1'b0, NO_RESULT},
    '{REQ_INSERT, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_RESULT},
    '{REQ_INSERT, 32'h0000_0000, 1'b1, 1'b0, NO_RESULT},
    '{REQ_INSERT, 32'h8000_0000, 1'b0, 1'b0, NO_RESULT},
    '{REQ_INSERT, 32'h7FFF_FFFF, 1'b0, 1'b0, NO_RESULT},
    '{REQ_INSERT, 32'h0000_1000, 1'b0, 1'b0, NO_RESULT},
    '{REQ_INSERT, 32'h0000_0000, 1'b0, 1'b0, NO_RESULT},
    '{REQ_INSERT, 32'hFFFF_FFFF, 1'b1, 1'b0, NO_RESULT},
    '{REQ_SEARCH, 32'h8000_0000, 1'b0, 1'b0, NO_RESULT},
    '{REQ_SEARCH, 32'h0000_0500, 1'b1, 1'b0, NO_RESULT},
    '{REQ_SEARCH, 32'h0000_0500, 1'b0, 1'b0, NO_RESULT},
    '{REQ_SEARCH, 32'h7FFF_FFFE, 1'b1, 1'b0, NO_RESULT},
    '{REQ_INSERT, 32'h5555_5555, 1'b0, 1'b0, NO_RESULT},
    '{REQ_INSERT, 32'hAAAA_AAAA, 1'b0, 1'b0, NO_RESULT},
    '{REQ_SEARCH, 32'h8000_0001, 1'b1, 1'b0, NO_RESULT}
  };

  sorted_table_insert_search_unit #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_BITS(32)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .key(key),
    .bracket(bracket),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_index(result_index),
    .exact_hit(exact_hit),
    .index_valid(index_valid),
    .table_full(table_full),
    .entries_now(entries_now)
  );

  always #5 clk = ~clk;

  function automatic int key_order(input logic [31:0] a, input logic [31:0] b);
    if (model_signed) begin
      if ($signed(a) < $signed(b)) return -1;
      if ($signed(a) > $signed(b)) return 1;
    end else begin
      if (a < b) return -1;
      if (a > b) return 1;
    end
    return 0;
  endfunction

  // fixed probe order: first, last, then midpoints until the bounds touch
  function automatic place_t find_place(input logic [31:0] k, input int n,
                                        output int lo, output int hi);
    int il;
    int ih;
    int im;
    int c;
    il = 0;
    ih = n - 1;
    lo = 0;
    hi = 0;
    c = key_order(table_model[il], k);
    if (c == 0) return PLACE_MATCH;
    if (c > 0) return PLACE_BELOW;
    c = key_order(table_model[ih], k);
    lo = ih;
    hi = ih;
    if (c == 0) return PLACE_MATCH;
    if (c < 0) return PLACE_ABOVE;
    while (ih - il > 1) begin
      im = (il + ih) / 2;
      c = key_order(table_model[im], k);
      if (c == 0) begin
        lo = im;
        hi = im;
        return PLACE_MATCH;
      end
      if (c > 0) ih = im;
      else il = im;
    end
    lo = il;
    hi = ih;
    return PLACE_BETWEEN;
  endfunction

  function automatic lookup_result_t predict_request(input logic rt, input logic [31:0] k,
                                                     input logic br);
    lookup_result_t r;
    place_t         where;
    int             n;
    int             lo;
    int             hi;
    int             pos;
    r = '0;
    n = model_count;
    if (rt == REQ_INSERT) begin
      if (n == 0) begin
        table_model[0] = k;
        model_count = 1;
        r.slot_valid = 1'b1;
      end else begin
        where = find_place(k, n, lo, hi);
        if (where == PLACE_MATCH) begin
          r.slot = hi[7:0];
          r.hit = 1'b1;
          r.slot_valid = 1'b1;
        end else if (n >= TABLE_DEPTH) begin
          r.full = 1'b1;
        end else begin
          if (where == PLACE_BELOW) pos = 0;
          else if (where == PLACE_ABOVE) pos = n;
          else pos = hi;
          for (int i = n; i > pos; i--) table_model[i] = table_model[i - 1];
          table_model[pos] = k;
          model_count = n + 1;
          r.slot = pos[7:0];
          r.slot_valid = 1'b1;
        end
      end
    end else if (n != 0) begin
      where = find_place(k, n, lo, hi);
      if (where == PLACE_MATCH) begin
        r.slot = hi[7:0];
        r.hit = 1'b1;
        r.slot_valid = 1'b1;
      end else if (br && where == PLACE_ABOVE) begin
        r.slot = 8'(n - 1);
        r.slot_valid = 1'b1;
      end else if (br && where == PLACE_BETWEEN) begin
        r.slot = lo[7:0];
        r.slot_valid = 1'b1;
      end
    end
    r.entries = 9'(model_count);
    return r;
  endfunction

  // stored keys, their neighbors, the extremes or anything
  function automatic logic [31:0] pick_key();
    int          sel;
    logic [31:0] k;
    sel = $urandom_range(99);
    k = $urandom;
    if (model_count != 0 && sel < 55) begin
      k = table_model[$urandom_range(model_count - 1)];
      if (sel >= 35) k = sel[0] ? k + 32'd1 : k - 32'd1;
    end else if (sel < 65) begin
      case ($urandom_range(3))
        0: k = 32'h0000_0000;
        1: k = 32'hFFFF_FFFF;
        2: k = 32'h8000_0000;
        default: k = 32'h7FFF_FFFF;
      endcase
    end
    return k;
  endfunction

  // one request beat; valid stays up into the next call unless a gap is taken
  task automatic send_request(input logic rt, input logic [31:0] k, input logic br,
                              input bit typed, input lookup_result_t want);
    lookup_result_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    key <= k;
    bracket <= br;
    do @(posedge clk); while (!in_ready);
    got = predict_request(rt, k, br);
    pending_results.push_back(typed ? want : got);
  endtask

  task automatic send_random(input int insert_pct);
    logic        rt;
    logic [31:0] k;
    rt = ($urandom_range(99) < insert_pct) ? REQ_INSERT : REQ_SEARCH;
    k = pick_key();
    if (rt == REQ_INSERT && $urandom_range(99) < 60) k = $urandom;
    send_request(rt, k, 1'($urandom_range(1)), 1'b0, NO_RESULT);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_key_signed(input bit value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_signed = value;
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (long_hold_go && !hold_taken) begin
      hold_left <= LONG_HOLD;
      hold_taken <= 1'b1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    lookup_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        err_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_index", want.slot, result_index);
        check_field("exact_hit", want.hit, exact_hit);
        check_field("index_valid", want.slot_valid, index_valid);
        check_field("table_full", want.full, table_full);
        check_field("entries_now", want.entries, entries_now);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_key_signed(1'b0);

    send_idle_pct = 28;
    recv_idle_pct = 64;
    for (int i = 0; i < N_DIRECTED; i++)
      send_request(directed_rows[i].req, directed_rows[i].k, directed_rows[i].br,
                   directed_rows[i].typed, directed_rows[i].want);
    for (int i = 0; i < 230; i++) send_random(45);
    drain_results();

    // signed order over a table built unsigned
    write_key_signed(1'b1);
    send_idle_pct = 64;
    recv_idle_pct = 28;
    for (int i = 0; i < 115; i++) send_random(45);
    drain_results();
    for (int i = 0; i < 115; i++) send_random(45);
    drain_results();

    write_key_signed(1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    long_hold_go <= 1'b1;
    while (model_count < TABLE_DEPTH) send_random(80);
    for (int i = 0; i < 40; i++) send_random(60);
    drain_results();

    write_key_signed(1'b1);
    for (int i = 0; i < 40; i++) send_random(50);
    drain_results();

    repeat (END_WAIT) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
